// ===== src/u64da_pkg.sv =====
// Shared constants and the power-of-ten table for the decimal text converter.
`timescale 1ns / 1ps
package u64da_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned SPACE_W = 16;
  localparam int unsigned NUM_DIGITS = 20;
  localparam int unsigned DIGIT_W = 5;
  localparam int unsigned STEP_W = 6;
  localparam logic [STEP_W-1:0] LAST_STEP = 6'd63;
  localparam logic [DIGIT_W-1:0] LAST_POW = 5'd19;
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  function automatic logic [VALUE_W-1:0] pow10(input logic [DIGIT_W-1:0] k);
    logic [VALUE_W-1:0] p;
    unique case (k)
      5'd0:  p = 64'd1;
      5'd1:  p = 64'd10;
      5'd2:  p = 64'd100;
      5'd3:  p = 64'd1000;
      5'd4:  p = 64'd10000;
      5'd5:  p = 64'd100000;
      5'd6:  p = 64'd1000000;
      5'd7:  p = 64'd10000000;
      5'd8:  p = 64'd100000000;
      5'd9:  p = 64'd1000000000;
      5'd10: p = 64'd10000000000;
      5'd11: p = 64'd100000000000;
      5'd12: p = 64'd1000000000000;
      5'd13: p = 64'd10000000000000;
      5'd14: p = 64'd100000000000000;
      5'd15: p = 64'd1000000000000000;
      5'd16: p = 64'd10000000000000000;
      5'd17: p = 64'd100000000000000000;
      5'd18: p = 64'd1000000000000000000;
      5'd19: p = 64'd10000000000000000000;
      default: p = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return p;
  endfunction

endpackage

// ===== src/u64_to_decimal_ascii.sv =====
// Unsigned 64-bit to ASCII decimal converter, top level.
//
// Pulse start while busy is low to hand in value and space. The block runs a
// shift-and-add-3 conversion one bit per cycle over all 64 bits. Alongside it,
// the block counts the digits with one power-of-ten compare per cycle. It then
// sends one beat per character, most significant first, one per cycle, marked
// by strobe. A value that does not fit in space gives a single beat with fits
// and text_length zero. Busy stays high through the conversion and all n beats
// (n is 1 to 20), and it drops while the last beat is on the ports, so the
// next item can be accepted while that beat is shown, not before. Beats cannot
// be held off: the receiver must take each one in the cycle it appears.
`timescale 1ns / 1ps
module u64_to_decimal_ascii
  import u64da_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [VALUE_W-1:0]   value,
  input  logic [SPACE_W-1:0]   space,
  output logic                 strobe,
  output logic [7:0]           char_code,
  output logic [DIGIT_W-1:0]   position,
  output logic [DIGIT_W-1:0]   text_length,
  output logic                 fits,
  output logic                 last
);

  state_t               state;
  logic [VALUE_W-1:0]   val;
  logic [VALUE_W-1:0]   bin;
  bcd_t                 bcd;
  bcd_t                 bcd_adj;
  logic [STEP_W-1:0]    step;
  logic [DIGIT_W-1:0]   kidx;
  logic [DIGIT_W-1:0]   ndig;
  logic [SPACE_W-1:0]   space_r;
  logic [DIGIT_W-1:0]   pos;
  logic [DIGIT_W-1:0]   sel;
  logic                 refuse;
  logic                 final_char;

  assign busy = (state != ST_IDLE);

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
  end

  assign sel        = ndig - 5'd1 - pos;
  assign refuse     = {{(SPACE_W-DIGIT_W){1'b0}}, ndig} > space_r;
  assign final_char = (pos == ndig - 5'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            val     <= value;
            bin     <= value;
            bcd     <= '0;
            space_r <= space;
            step    <= '0;
            kidx    <= 5'd1;
            ndig    <= 5'd1;
            pos     <= '0;
            state   <= ST_CONV;
          end
        end
        ST_CONV: begin
          {bcd, bin} <= {bcd_adj, bin} << 1;
          if (kidx <= LAST_POW) begin
            if (val >= pow10(kidx)) begin
              ndig <= ndig + 5'd1;
            end
            kidx <= kidx + 5'd1;
          end
          step <= step + 6'd1;
          if (step == LAST_STEP) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          strobe <= 1'b1;
          if (refuse) begin
            char_code   <= 8'd0;
            position    <= '0;
            text_length <= '0;
            fits        <= 1'b0;
            last        <= 1'b1;
            state       <= ST_IDLE;
          end else begin
            char_code   <= ASCII_ZERO + {4'd0, bcd[sel]};
            position    <= pos;
            text_length <= ndig;
            fits        <= 1'b1;
            last        <= final_char;
            pos         <= pos + 5'd1;
            if (final_char) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
